// ===== src/pswn_pkg.sv =====
// shared types, widths and constants of the proportional share weight normalizer
package pswn_pkg;

   // field widths
   localparam int SCORE_W    = 24;
   localparam int SCALE_W    = 16;
   localparam int MINP_W     = 6;
   localparam int IDX_OUT_W  = 6;
   localparam int SHARE_W    = 13;
   localparam int RAW_W      = 15;
   localparam int TOTAL_W    = 21;
   localparam int K_W        = 23;
   localparam int NUM_W      = 47;
   localparam int DEN_W      = 32;
   localparam int QUOT_W     = 15;
   localparam int STEP_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_ENTRIES_DEF = 64;

   // arithmetic constants
   localparam logic [SCORE_W-1:0] SCORE_FLOOR = 24'd26;
   localparam logic [RAW_W-1:0]   UNIT_WEIGHT = 15'd100;
   localparam logic [SCALE_W-1:0] ONE_Q8      = 16'd256;
   localparam logic [MINP_W-1:0]  MIN_LO      = 6'd1;
   localparam logic [MINP_W-1:0]  MIN_HI      = 6'd50;

   // reset values of the registers
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd2560;
   localparam logic [MINP_W-1:0]  MINP_RESET  = 6'd10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MINP  = 1'b1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_READ,
      ST_MUL,
      ST_DIV,
      ST_WAIT,
      ST_WB
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

endpackage

// ===== src/pswn_chan_if.sv =====
// valid/ready channel interfaces for score input and weight output
interface req_if;
   import pswn_pkg::*;
   logic               valid;
   logic               ready;
   logic [SCORE_W-1:0] score;
   logic               last_entry;

   modport source (output valid, output score, output last_entry, input ready);
   modport sink   (input valid, input score, input last_entry, output ready);
endinterface

interface rsp_if;
   import pswn_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [IDX_OUT_W-1:0] entry_index;
   logic [SHARE_W-1:0]   share_weight;
   logic                 last_weight;

   modport source (output valid, output entry_index, output share_weight,
                   output last_weight, input ready);
   modport sink   (input valid, input entry_index, input share_weight,
                   input last_weight, output ready);
endinterface

// ===== src/pswn_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module pswn_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pswn_pkg::div_req_type div_req,
   output pswn_pkg::div_rsp_type div_rsp
);
   import pswn_pkg::*;

   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  dsr_ff, dsr_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              fits;
   logic [NUM_W-1:0]  diff;

   always_comb begin
      diff    = rem_ff - dsr_ff;
      fits    = rem_ff >= dsr_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.numer;
         dsr_in  = NUM_W'(div_req.denom) << (QUOT_W - 1);
         quot_in = '0;
         step_in = STEP_W'(QUOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = diff;
         end
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         dsr_in  = dsr_ff >> 1;
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// ===== src/proportional_share_weight_normalizer.sv =====
// top level: score and raw weight stores, sequencer, shared multiplier and divider, output register
//
//   channel  dir  handshake          payload
//   req_bus  in   valid/ready        score, last_entry
//   rsp_bus  out  valid/ready        entry_index, share_weight, last_weight
//   csr      in   csr_we (no ready)  csr_index, csr_wdata
//
// scores load at one per cycle; the transfer marked last starts the computation
// each entry then takes two passes (read, multiply, divide, write back)
// req_bus.ready is low from the last transfer until the final weight is in the
// output register; a stalled rsp_bus holds the sequencer at the emit step
// reset is synchronous and clears control state and the registers to defaults
module proportional_share_weight_normalizer #(
   parameter int MAX_ENTRIES = pswn_pkg::MAX_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   req_if.sink                             req_bus,
   rsp_if.source                           rsp_bus,
   input  logic                            csr_we,
   input  logic [pswn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pswn_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pswn_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

   // sequencer
   state_type state_ff, state_in;
   logic      pass2_ff, pass2_in;

   // run state
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [SCORE_W-1:0] max_ff, max_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic [MINP_W-1:0]  lo_ff, lo_in;
   logic [SHARE_W-1:0] n100_ff, n100_in;
   logic [NUM_W-1:0]   mul_ff, mul_in;

   // registers
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [MINP_W-1:0]  minp_ff, minp_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic [IDX_OUT_W-1:0] out_idx_ff, out_idx_in;
   logic [SHARE_W-1:0]   out_share_ff, out_share_in;
   logic                 out_last_ff, out_last_in;

   // memories and their read registers
   logic [SCORE_W-1:0] score_mem [0:MAX_ENTRIES-1];
   logic [RAW_W-1:0]   raw_mem [0:MAX_ENTRIES-1];
   logic [SCORE_W-1:0] score_rd_ff;
   logic [RAW_W-1:0]   raw_rd_ff;

   // sequencer strobes
   logic load_go, rd_go, div_go, wb_go;
   logic accept, store_ok, out_free, last_of_pass, run_empty;

   // arithmetic
   logic [SCALE_W-1:0] sc_eff;
   logic [MINP_W-1:0]  lo_now;
   logic [SCORE_W-1:0] op_a;
   logic [K_W-1:0]     op_b;
   logic [RAW_W-1:0]   raw_val;
   logic [SHARE_W-1:0] share_val;

   div_req_type div_req;
   div_rsp_type div_rsp;

   pswn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept       = req_bus.valid && req_bus.ready;
   assign store_ok     = cnt_ff < CNT_MAX;
   assign run_empty    = (cnt_ff == '0) && !store_ok;
   assign out_free     = !out_valid_ff || rsp_bus.ready;
   assign last_of_pass = (idx_ff + CNT_W'(1)) == cnt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && req_bus.last_entry && !run_empty) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_MUL;
         ST_MUL:  state_in = ST_DIV;
         ST_DIV:  state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            if (!pass2_ff) begin
               state_in = ST_READ;
            end else if (out_free) begin
               state_in = last_of_pass ? ST_LOAD : ST_READ;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_bus.ready = 1'b0;
      load_go       = 1'b0;
      rd_go         = 1'b0;
      div_go        = 1'b0;
      wb_go         = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_bus.ready = 1'b1;
            load_go       = accept;
         end
         ST_READ: rd_go  = 1'b1;
         ST_MUL:  ;
         ST_DIV:  div_go = 1'b1;
         ST_WAIT: ;
         ST_WB:   wb_go  = !pass2_ff || out_free;
         default: ;
      endcase
   end

   // scale below 1.0 acts as 1.0, minimum percent saturates into its range
   always_comb begin
      sc_eff = (scale_ff < ONE_Q8) ? ONE_Q8 : scale_ff;
      lo_now = minp_ff;
      if (minp_ff < MIN_LO) begin
         lo_now = MIN_LO;
      end else if (minp_ff > MIN_HI) begin
         lo_now = MIN_HI;
      end
   end

   // shared multiplier: k*score in the first pass, raw*count*100 in the second
   always_comb begin
      op_a   = pass2_ff ? SCORE_W'(raw_rd_ff) : score_rd_ff;
      op_b   = pass2_ff ? K_W'(n100_ff) : k_ff;
      mul_in = NUM_W'(op_a) * NUM_W'(op_b);
   end

   always_comb begin
      div_req.start = div_go;
      div_req.numer = mul_ff;
      div_req.denom = pass2_ff ? DEN_W'(total_ff) : {max_ff, 8'b0};
   end

   // write-back values: quotients stay below 2^15 and 6401 by the value ranges
   always_comb begin
      raw_val = UNIT_WEIGHT + div_rsp.quot;
      if (raw_val < RAW_W'(lo_ff)) begin
         raw_val = RAW_W'(lo_ff);
      end
      share_val = SHARE_W'(div_rsp.quot);
      if (share_val < SHARE_W'(lo_ff)) begin
         share_val = SHARE_W'(lo_ff);
      end
   end

   // run state and output register
   always_comb begin
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      max_in       = max_ff;
      total_in     = total_ff;
      k_in         = k_ff;
      lo_in        = lo_ff;
      n100_in      = n100_ff;
      pass2_in     = pass2_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_idx_in   = out_idx_ff;
      out_share_in = out_share_ff;
      out_last_in  = out_last_ff;

      if (load_go) begin
         if (store_ok) begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (req_bus.score > max_ff) begin
               max_in = req_bus.score;
            end
         end
         if (req_bus.last_entry) begin
            idx_in   = '0;
            pass2_in = 1'b0;
            total_in = '0;
            k_in     = K_W'(32'(sc_eff - ONE_Q8) * 32'(UNIT_WEIGHT));
            lo_in    = lo_now;
            if (run_empty) begin
               cnt_in = '0;
               max_in = SCORE_FLOOR;
            end
         end
      end

      if (wb_go) begin
         idx_in = idx_ff + CNT_W'(1);
         if (!pass2_ff) begin
            total_in = total_ff + TOTAL_W'(raw_val);
            if (last_of_pass) begin
               idx_in   = '0;
               pass2_in = 1'b1;
               n100_in  = SHARE_W'(cnt_ff) * SHARE_W'(UNIT_WEIGHT);
            end
         end else begin
            out_valid_in = 1'b1;
            out_idx_in   = IDX_OUT_W'(idx_ff);
            out_share_in = share_val;
            out_last_in  = last_of_pass;
            if (last_of_pass) begin
               // run done: back to the empty set
               idx_in   = '0;
               cnt_in   = '0;
               max_in   = SCORE_FLOOR;
               total_in = '0;
               pass2_in = 1'b0;
            end
         end
      end
   end

   // register writes
   always_comb begin
      scale_in = scale_ff;
      minp_in  = minp_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SCALE: scale_in = csr_wdata;
            CSR_MINP:  minp_in  = csr_wdata[MINP_W-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      lo_ff        <= lo_in;
      n100_ff      <= n100_in;
      mul_ff       <= mul_in;
      out_idx_ff   <= out_idx_in;
      out_share_ff <= out_share_in;
      out_last_ff  <= out_last_in;
      if (reset) begin
         state_ff     <= ST_LOAD;
         pass2_ff     <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         max_ff       <= SCORE_FLOOR;
         total_ff     <= '0;
         scale_ff     <= SCALE_RESET;
         minp_ff      <= MINP_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass2_ff     <= pass2_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         max_ff       <= max_in;
         total_ff     <= total_in;
         scale_ff     <= scale_in;
         minp_ff      <= minp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // score store
   always_ff @(posedge clock) begin
      if (load_go && store_ok) begin
         score_mem[cnt_ff[IDX_W-1:0]] <= req_bus.score;
      end
      if (rd_go) begin
         score_rd_ff <= score_mem[idx_ff[IDX_W-1:0]];
      end
   end

   // raw weight store
   always_ff @(posedge clock) begin
      if (wb_go && !pass2_ff) begin
         raw_mem[idx_ff[IDX_W-1:0]] <= raw_val;
      end
      if (rd_go) begin
         raw_rd_ff <= raw_mem[idx_ff[IDX_W-1:0]];
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.entry_index  = out_idx_ff;
   assign rsp_bus.share_weight = out_share_ff;
   assign rsp_bus.last_weight  = out_last_ff;

endmodule
